@@ rtl/rfe_pkg.sv @@
// ----------------------------------------------------------------------------
// rfe_pkg: shared types, constants and arithmetic helpers
// Fixed-point widths, cosine series coefficients, the queue item record and
// the rounded multiply used by the cosine evaluation pipeline.
// ----------------------------------------------------------------------------
package rfe_pkg;

	localparam int unsigned MAX_DIMS_DEF   = 64;
	// phase resolution in bits of one turn
	localparam int unsigned COS_TABLE_BITS = 10;

	localparam int unsigned COORD_W = 24;
	localparam int unsigned FIT_W   = 40;
	localparam int unsigned SQ_W    = 31;   // rounded square, Q.16, at most 2^30
	localparam int unsigned W_W     = 29;   // u*u in Q32 turns^2, at most 2^28
	localparam int unsigned COEF_W  = 35;   // Horner accumulator, Q28
	localparam int unsigned PROD_W  = 32;   // rounded w*h, at most 2^31
	localparam int unsigned TERM_W  = 32;   // per-coordinate term incl. bias
	localparam int unsigned SUM_W   = 41;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [COEF_W-1:0] COS_C1 = 35'd5298703516;
	localparam logic [COEF_W-1:0] COS_C2 = 35'd17432035847;
	localparam logic [COEF_W-1:0] COS_C3 = 35'd22939639695;
	localparam logic [COEF_W-1:0] COS_C4 = 35'd16171797778;
	localparam logic [COEF_W-1:0] COS_C5 = 35'd7093744290;

	localparam logic [PROD_W-1:0] COS_ONE_Q28 = 32'h1000_0000;
	localparam logic [28:0]       Q16_HALF    = 29'd2048;
	// ten per counted dimension, Q16
	localparam logic [TERM_W-1:0] DIM_BIAS    = 32'd655360;
	localparam logic [FIT_W-1:0]  FIT_MAX     = {FIT_W{1'b1}};

	localparam logic [15:0] PHASE_MASK = ~16'((1 << (16 - COS_TABLE_BITS)) - 1);

	typedef struct packed {
		logic [SQ_W-1:0]  sq16;
		logic [W_W-1:0]   w;
		logic             neg;
		logic             last;
		logic             counted;
		logic [FIT_W-1:0] prev;
	} rfe_item_t;

	typedef struct packed {
		logic                  full;
		logic                  empty;
		logic [FIFO_LVL_W-1:0] level;
	} rfe_fifo_status_t;

	// (w*h + 2^31) >> 32
	function automatic logic [PROD_W-1:0] rnd_mul(input logic [W_W-1:0] w,
		input logic [COEF_W-1:0] h);
		logic [63:0] prod;
		logic [63:0] sum;
		prod = 64'(w) * 64'(h);
		sum  = prod + 64'h0000_0000_8000_0000;
		return sum[63:32];
	endfunction

	// one Horner step: c - round(w*h)
	function automatic logic [COEF_W-1:0] horner_step(input logic [W_W-1:0] w,
		input logic [COEF_W-1:0] h, input logic [COEF_W-1:0] c);
		return c - COEF_W'(rnd_mul(w, h));
	endfunction

endpackage

@@ rtl/rfe_fifo.sv @@
// ----------------------------------------------------------------------------
// rfe_fifo: short item queue
// Decouples the classifying front end from the cosine/accumulate back end.
// ----------------------------------------------------------------------------
module rfe_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  rfe_pkg::rfe_item_t        push_item,
	input  logic                      pop,
	output rfe_pkg::rfe_item_t        head,
	output rfe_pkg::rfe_fifo_status_t st
);

	rfe_pkg::rfe_item_t                 entries_q [rfe_pkg::FIFO_DEPTH];
	logic [rfe_pkg::FIFO_PTR_W-1:0]     wr_ptr_q;
	logic [rfe_pkg::FIFO_PTR_W-1:0]     rd_ptr_q;
	logic [rfe_pkg::FIFO_LVL_W-1:0]     level_q;
	logic                               do_push;
	logic                               do_pop;

	assign st.full  = (level_q == rfe_pkg::FIFO_LVL_W'(rfe_pkg::FIFO_DEPTH));
	assign st.empty = (level_q == '0);
	assign st.level = level_q;
	assign head     = entries_q[rd_ptr_q];

	assign do_push = push && !st.full;
	assign do_pop  = pop && !st.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == rfe_pkg::FIFO_PTR_W'(rfe_pkg::FIFO_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == rfe_pkg::FIFO_PTR_W'(rfe_pkg::FIFO_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ rtl/rfe_front.sv @@
// ----------------------------------------------------------------------------
// rfe_front: coordinate intake and classification
// Counts dimensions, drops coordinates beyond the limit, squares the
// coordinate and folds its phase into the first quadrant.
// ----------------------------------------------------------------------------
module rfe_front #(
	parameter int unsigned MAX_DIMS = rfe_pkg::MAX_DIMS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [63:0]                     s_axis_tdata,
	input  logic                            s_axis_tlast,
	input  rfe_pkg::rfe_fifo_status_t       fifo_st,
	output logic                            push,
	output rfe_pkg::rfe_item_t              push_item
);

	localparam int unsigned CNT_W = $clog2(MAX_DIMS + 1);

	logic [CNT_W-1:0]                       dim_count_q;
	logic                                   counted;
	logic                                   accept;
	logic                                   valid_s1;
	logic signed [rfe_pkg::COORD_W-1:0]     coord_s1;
	logic                                   last_s1;
	logic                                   counted_s1;
	logic [rfe_pkg::FIT_W-1:0]              prev_s1;
	logic signed [47:0]                     sq_full;
	logic [47:0]                            sq_rnd;
	logic [15:0]                            phase;
	logic [14:0]                            u;

	assign counted       = (dim_count_q < CNT_W'(MAX_DIMS));
	assign s_axis_tready = !valid_s1 || !fifo_st.full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign push          = valid_s1 && !fifo_st.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			dim_count_q <= '0;
		end else begin
			if (s_axis_tready) begin
				// drop coordinates past the limit unless they close the particle
				valid_s1 <= accept && (counted || s_axis_tlast);
			end
			if (accept) begin
				if (s_axis_tlast) begin
					dim_count_q <= '0;
				end else if (counted) begin
					dim_count_q <= dim_count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			coord_s1   <= s_axis_tdata[rfe_pkg::COORD_W-1:0];
			prev_s1    <= s_axis_tdata[rfe_pkg::COORD_W +: rfe_pkg::FIT_W];
			last_s1    <= s_axis_tlast;
			counted_s1 <= counted;
		end
	end

	always_comb begin
		sq_full = coord_s1 * coord_s1;
		sq_rnd  = 48'(sq_full) + 48'h0000_0000_8000;
		phase   = coord_s1[15:0] & rfe_pkg::PHASE_MASK;
		// odd quadrants mirror about the quarter turn
		u       = phase[14] ? (15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};

		push_item.sq16    = sq_rnd[46:16];
		push_item.w       = rfe_pkg::W_W'(u) * rfe_pkg::W_W'(u);
		push_item.neg     = phase[15] ^ phase[14];
		push_item.last    = last_s1;
		push_item.counted = counted_s1;
		push_item.prev    = prev_s1;
	end

endmodule

@@ rtl/rfe_back.sv @@
// ----------------------------------------------------------------------------
// rfe_back: cosine series, accumulation and result register
// Five-stage Horner pipeline, term formation, running sum and the
// saturating fitness output with the personal-best compare.
// ----------------------------------------------------------------------------
module rfe_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rfe_pkg::rfe_item_t          head,
	input  rfe_pkg::rfe_fifo_status_t   fifo_st,
	output logic                        pop,
	input  logic                        minimize,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [39:0]                 m_axis_tdata,
	output logic                        m_axis_tuser
);

	logic                               en;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	rfe_pkg::rfe_item_t item_s1, item_s2, item_s3, item_s4, item_s5;
	logic [rfe_pkg::COEF_W-1:0] h_s1, h_s2, h_s3, h_s4;
	logic [rfe_pkg::PROD_W-1:0]         p_s5;
	logic [rfe_pkg::TERM_W-1:0]         term_s6;
	logic                               last_s6;
	logic [rfe_pkg::FIT_W-1:0]          prev_s6;
	logic [rfe_pkg::SUM_W-1:0]          res_s7;
	logic [rfe_pkg::FIT_W-1:0]          prev_s7;
	logic [rfe_pkg::SUM_W-1:0]          sum_q;
	logic                               out_valid_q;
	logic [rfe_pkg::FIT_W-1:0]          fit_q;
	logic                               best_q;
	logic [28:0]                        r;
	logic [28:0]                        r_rnd;
	logic [16:0]                        mag;
	logic [20:0]                        mag10;
	logic [rfe_pkg::TERM_W-1:0]         term_next;
	logic [rfe_pkg::SUM_W-1:0]          acc_next;
	logic [rfe_pkg::FIT_W-1:0]          fit_next;

	// the whole back end holds while a result waits at the output
	assign en            = !out_valid_q || m_axis_tready;
	assign pop           = en && !fifo_st.empty;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = fit_q;
	assign m_axis_tuser  = best_q;

	always_comb begin
		r     = (p_s5 >= rfe_pkg::COS_ONE_Q28) ? '0 : 29'(rfe_pkg::COS_ONE_Q28 - p_s5);
		r_rnd = r + rfe_pkg::Q16_HALF;
		mag   = r_rnd[28:12];
		mag10 = 21'({mag, 3'b000}) + 21'({mag, 1'b0});
		if (!item_s5.counted) begin
			term_next = '0;
		end else if (item_s5.neg) begin
			term_next = rfe_pkg::TERM_W'(item_s5.sq16) + rfe_pkg::DIM_BIAS
				+ rfe_pkg::TERM_W'(mag10);
		end else begin
			term_next = rfe_pkg::TERM_W'(item_s5.sq16) + rfe_pkg::DIM_BIAS
				- rfe_pkg::TERM_W'(mag10);
		end
		acc_next = sum_q + rfe_pkg::SUM_W'(term_s6);
		fit_next = res_s7[rfe_pkg::SUM_W-1] ? rfe_pkg::FIT_MAX : res_s7[rfe_pkg::FIT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			valid_s6    <= 1'b0;
			valid_s7    <= 1'b0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= pop;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			valid_s5    <= valid_s4;
			valid_s6    <= valid_s5;
			valid_s7    <= valid_s6 && last_s6;
			out_valid_q <= valid_s7;
			if (valid_s6) begin
				sum_q <= last_s6 ? '0 : acc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= head;
			h_s1    <= rfe_pkg::horner_step(head.w, rfe_pkg::COS_C5, rfe_pkg::COS_C4);
			item_s2 <= item_s1;
			h_s2    <= rfe_pkg::horner_step(item_s1.w, h_s1, rfe_pkg::COS_C3);
			item_s3 <= item_s2;
			h_s3    <= rfe_pkg::horner_step(item_s2.w, h_s2, rfe_pkg::COS_C2);
			item_s4 <= item_s3;
			h_s4    <= rfe_pkg::horner_step(item_s3.w, h_s3, rfe_pkg::COS_C1);
			item_s5 <= item_s4;
			p_s5    <= rfe_pkg::rnd_mul(item_s4.w, h_s4);
			term_s6 <= term_next;
			last_s6 <= item_s5.last;
			prev_s6 <= item_s5.prev;
			res_s7  <= acc_next;
			prev_s7 <= prev_s6;
			fit_q   <= fit_next;
			best_q  <= minimize && (fit_next < prev_s7);
		end
	end

endmodule

@@ rtl/rastrigin_fitness_evaluator_unit.sv @@
// A last coordinate's fitness reaches m_axis via the front register, the queue, back stages s1-s7 and fit_q.
// Throughput: one coordinate per cycle; the queue between front and back absorbs
// output stalls until it fills, then s_axis_tready drops.
// Five-stage Horner multiply pipeline (one product per stage); it holds on output stalls.
// Reset (arst_n low): queue, pipeline, sum and dimension count clear; minimize_mode = 1.
// ----------------------------------------------------------------------------
// rastrigin_fitness_evaluator_unit: streaming Rastrigin fitness
// Accumulates x^2 - 10*cos(2*pi*x) + 10 per coordinate and emits the
// saturated fitness with a personal-best flag on each particle's last item.
// ----------------------------------------------------------------------------
module rastrigin_fitness_evaluator_unit #(
	parameter int unsigned MAX_DIMS = rfe_pkg::MAX_DIMS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// coordinate stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [23:0] coord_value, [63:24] prev_fitness
	input  logic        s_axis_tlast,   // last_coord
	// fitness stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [39:0] fitness_value
	output logic        m_axis_tuser,   // [0] take_as_best
	// configuration: minimize_mode
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	logic                         minimize_q;
	logic                         push;
	logic                         pop;
	rfe_pkg::rfe_item_t           push_item;
	rfe_pkg::rfe_item_t           head;
	rfe_pkg::rfe_fifo_status_t    fifo_st;

	// config writes are registered into minimize_q and always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			minimize_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			minimize_q <= cfg_data;
		end
	end

	// front end: take coordinate transfers, count and classify, square and fold phase
	rfe_front #(
		.MAX_DIMS (MAX_DIMS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.fifo_st       (fifo_st),
		.push          (push),
		.push_item     (push_item)
	);

	// queue: lets the front keep accepting while the back holds a result
	rfe_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.st        (fifo_st)
	);

	// back end: cosine series, accumulate, saturate and compare
	rfe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.fifo_st       (fifo_st),
		.pop           (pop),
		.minimize      (minimize_q),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

`ifndef SYNTH
	// the front only stalls its input when the queue is full
	a_stall_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> fifo_st.full)
		else $error("input stalled with room in the queue");

	// queue level never exceeds its depth
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_st.level <= rfe_pkg::FIFO_LVL_W'(rfe_pkg::FIFO_DEPTH))
		else $error("queue level overflow");

	// the best flag is only raised in minimization mode
	a_best_needs_min: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> minimize_q)
		else $error("take_as_best set with minimization off");
`endif

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: Rastrigin fitness evaluator stream check
// Streams particles of signed Q8.16 coordinates into the evaluator with random
// gaps and output back-pressure. An in-bench fixed-point model computes each
// particle's fitness and personal-best flag. Every fitness transfer is
// compared in order against that model. The run covers both minimization
// settings, particles longer than the dimension limit and a long output
// stall that fills the block.
// ----------------------------------------------------------------------------
module testbench;

	localparam int          DIM_LIMIT   = 64;
	localparam int          PHASE_BITS  = 10;
	localparam longint      FIT_TOP     = 64'h00FF_FFFF_FFFF;
	localparam longint      DIM_BONUS   = 655360;   // ten per dimension, Q16
	localparam int          DRAIN_WAIT  = 24;
	localparam int          LONG_STALL  = 400;
	localparam longint      TIMEOUT_NS  = 64'd10_000_000;

	typedef enum int {PREV_MAX, PREV_ZERO, PREV_EQUAL, PREV_ABOVE, PREV_BELOW,
		PREV_NEAR, PREV_RANDOM} prev_pick_e;

	typedef struct {
		logic [39:0] fitness;
		bit          best;
	} fitness_rec_t;

	// ------------------------------------------------------------------------
	// fitness model and in-order result check
	// ------------------------------------------------------------------------
	class fitness_scoreboard;
		bit                best_enable;
		longint            acc;
		int                dim_seen;
		longint unsigned   series[5];
		fitness_rec_t      fitness_due[$];
		int                errors;

		function new();
			best_enable = 1'b1;
			acc         = 0;
			dim_seen    = 0;
			errors      = 0;
			series[0]   = 64'd5298703516;
			series[1]   = 64'd17432035847;
			series[2]   = 64'd22939639695;
			series[3]   = 64'd16171797778;
			series[4]   = 64'd7093744290;
		endfunction

		task report(string what);
			errors++;
			if (errors <= 50) begin
				$display("MISMATCH at %0t ns: %s", $time, what);
			end
		endtask

		// cos(2*pi*phase) in Q16; phase is 1/65536 of a turn
		function longint cos_q16(logic [15:0] phase);
			logic [1:0]      quad;
			longint unsigned u;
			longint unsigned w;
			longint unsigned h;
			longint unsigned p;
			longint unsigned r;
			longint          mag;
			quad = phase[15:14];
			u = quad[0] ? (64'h4000 - 64'(phase[13:0])) : 64'(phase[13:0]);
			w = u * u;
			h = series[4];
			for (int k = 3; k >= 0; k--) begin
				p = (w * h + 64'h8000_0000) >> 32;
				h = series[k] - p;
			end
			p = (w * h + 64'h8000_0000) >> 32;
			r = (p >= 64'h1000_0000) ? 64'd0 : 64'h1000_0000 - p;
			mag = longint'((r + 64'd2048) >> 12);
			return (quad == 2'd1 || quad == 2'd2) ? -mag : mag;
		endfunction

		// one coordinate's share: rounded square minus ten cosines
		function longint coord_term(logic [23:0] coord);
			longint      x;
			longint      sq16;
			logic [15:0] phase;
			x     = longint'($signed(coord));
			sq16  = (x * x + 64'sd32768) >>> 16;
			phase = coord[15:0] & ~16'((1 << (16 - PHASE_BITS)) - 1);
			return sq16 - 10 * cos_q16(phase);
		endfunction

		// fitness the particle would get if this coordinate closed it
		function logic [39:0] fitness_if_last(logic [23:0] coord);
			longint total;
			int     dims;
			total = acc;
			dims  = dim_seen;
			if (dims < DIM_LIMIT) begin
				total += coord_term(coord);
				dims++;
			end
			total += DIM_BONUS * dims;
			if (total < 0) total = 0;
			if (total > FIT_TOP) total = FIT_TOP;
			return total[39:0];
		endfunction

		function void set_mode(bit mode);
			best_enable = mode;
		endfunction

		function void note_coord(logic [23:0] coord, bit last, logic [39:0] prev);
			fitness_rec_t rec;
			if (last) begin
				rec.fitness = fitness_if_last(coord);
				rec.best    = best_enable && (rec.fitness < prev);
				fitness_due.push_back(rec);
				acc      = 0;
				dim_seen = 0;
			end else if (dim_seen < DIM_LIMIT) begin
				acc += coord_term(coord);
				dim_seen++;
			end
		endfunction

		task check_fitness(logic [39:0] fitness, logic best);
			fitness_rec_t rec;
			if (fitness_due.size() == 0) begin
				report($sformatf("fitness %h arrived with nothing outstanding", fitness));
			end else begin
				rec = fitness_due.pop_front();
				if (fitness !== rec.fitness)
					report($sformatf("fitness %h, model %h", fitness, rec.fitness));
				if (best !== rec.best)
					report($sformatf("best flag %b, model %b (fitness %h)",
						best, rec.best, rec.fitness));
			end
		endtask

		function int pending();
			return fitness_due.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;   // [23:0] coord_value, [63:24] prev_fitness
	logic        s_axis_tlast;   // last_coord
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;   // [39:0] fitness_value
	logic        m_axis_tuser;   // [0] take_as_best
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;

	fitness_scoreboard sb;
	bit                stall_req;

	rastrigin_fitness_evaluator_unit #(.MAX_DIMS(DIM_LIMIT)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Simulation FAILED");
		$finish;
	end

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [23:0] pick_coord();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: begin
				case ($urandom_range(0, 3))
					0: return 24'h800000;
					1: return 24'h7FFFFF;
					2: return 24'h000000;
					default: return 24'hFFFFFF;
				endcase
			end
			1, 2: begin
				// near zero, where the cosine term dominates
				return $urandom_range(0, 1) ? 24'($urandom_range(0, 24'h3FFFF))
					: -24'($urandom_range(0, 24'h3FFFF));
			end
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [39:0] pick_prev(logic [39:0] fit, prev_pick_e kind);
		longint v;
		v = longint'(fit);
		case (kind)
			PREV_MAX:    v = FIT_TOP;
			PREV_ZERO:   v = 0;
			PREV_EQUAL:  v = longint'(fit);
			PREV_ABOVE:  v = longint'(fit) + 1;
			PREV_BELOW:  v = longint'(fit) - 1;
			PREV_NEAR:   v = longint'(fit) + $urandom_range(0, 2000) - 1000;
			default:     v = longint'({$urandom, $urandom}) & FIT_TOP;
		endcase
		if (v < 0) v = 0;
		if (v > FIT_TOP) v = FIT_TOP;
		return v[39:0];
	endfunction

	function automatic int pick_dims(bit short_only);
		int r;
		if (short_only) return $urandom_range(1, 3);
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(1, 8);
		if (r < 95) return $urandom_range(9, DIM_LIMIT);
		return $urandom_range(DIM_LIMIT + 1, DIM_LIMIT + 8);
	endfunction

	// offer one coordinate, hold it until the transfer, then log it
	task automatic send_coord(logic [23:0] coord, bit last, logic [39:0] prev, int gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= {$urandom, $urandom};
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {prev, coord};
		s_axis_tlast  <= last;
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		sb.note_coord(coord, last, prev);
	endtask

	task automatic send_particle(int dims, bit burst);
		logic [23:0] coord;
		logic [39:0] prev;
		for (int i = 0; i < dims; i++) begin
			coord = pick_coord();
			if (i == dims - 1)
				prev = pick_prev(sb.fitness_if_last(coord),
					prev_pick_e'($urandom_range(PREV_MAX, PREV_RANDOM)));
			else
				prev = 40'({$urandom, $urandom});
			send_coord(coord, i == dims - 1, prev, burst ? 0 : pick_gap());
		end
	endtask

	task automatic random_phase(int n_items, bit short_only);
		int sent;
		int dims;
		sent = 0;
		while (sent < n_items) begin
			dims = pick_dims(short_only);
			send_particle(dims, $urandom_range(0, 3) == 0);
			sent += dims;
		end
	endtask

	// drop valid, wait for every fitness, then let the pipeline empty
	task automatic drain_block();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_mode(bit mode);
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		sb.set_mode(mode);
		@(posedge clk);
	endtask

	// quadrant edges, field extremes, strict compare, sign, phase truncation
	task automatic run_directed();
		logic [23:0] dir_coord [14];
		bit          dir_last  [14];
		prev_pick_e  dir_pick  [14];
		logic [39:0] fit;
		dir_coord = '{24'h000000, 24'h000000, 24'h7FFFFF, 24'h800000,
			24'h004000, 24'h008000, 24'h00C000, 24'h00FFFF, 24'hFFFFFF,
			24'hFF0000, 24'h00003F, 24'h7FFFC0, 24'h002000, 24'hFFE000};
		dir_last  = '{1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1};
		dir_pick  = '{PREV_MAX, PREV_ZERO, PREV_EQUAL, PREV_ABOVE, PREV_RANDOM,
			PREV_RANDOM, PREV_RANDOM, PREV_RANDOM, PREV_RANDOM, PREV_RANDOM,
			PREV_RANDOM, PREV_BELOW, PREV_RANDOM, PREV_NEAR};
		for (int i = 0; i < 14; i++) begin
			fit = sb.fitness_if_last(dir_coord[i]);
			send_coord(dir_coord[i], dir_last[i], pick_prev(fit, dir_pick[i]), 0);
		end
	endtask

	// fitness sink: random back-pressure, one long hold on request
	initial begin : fitness_sink
		int hold;
		int run;
		hold = 0;
		run  = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(negedge clk);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_fitness(m_axis_tdata, m_axis_tuser);
			@(posedge clk);
			if (stall_req) begin
				stall_req = 1'b0;
				hold = LONG_STALL;
			end
			if (run == 0 && hold == 0) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: hold = 0;
					5, 6, 7:       hold = $urandom_range(1, 4);
					8:             hold = $urandom_range(5, 15);
					default:       hold = $urandom_range(30, 80);
				endcase
				run = $urandom_range(1, 24);
			end
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				hold--;
			end else begin
				m_axis_tready <= 1'b1;
				run--;
			end
		end
	end

	initial begin
		sb = new();
		stall_req = 1'b0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tlast  <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_data      <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of the mode is on: check it before any write
		run_directed();
		drain_block();

		write_mode(1'b0);
		random_phase(500, 1'b0);
		drain_block();

		// short particles while the sink holds off: fill the block
		write_mode(1'b1);
		stall_req = 1'b1;
		random_phase(500, 1'b1);
		drain_block();

		write_mode(1'b0);
		random_phase(350, 1'b0);
		drain_block();

		write_mode(1'b1);
		random_phase(450, 1'b0);
		drain_block();

		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/rfe_pkg.sv
rtl/rfe_fifo.sv
rtl/rfe_front.sv
rtl/rfe_back.sv
rtl/rastrigin_fitness_evaluator_unit.sv
dv/testbench.sv
